>>> src/erp_pkg.sv
// Shared constants, types and helper functions for the Euler point rotator.
`default_nettype none

package erp_pkg;

   // Field widths.
   localparam int COORD_BITS = 20;
   localparam int ANGLE_BITS = 16;

   // Angle folding works on a full turn of 2^TURN_BITS.
   localparam int TURN_BITS = 32;
   localparam logic [TURN_BITS-1:0] HALF_QUAD = TURN_BITS'(64'd1 << (TURN_BITS - 3));

   // CORDIC datapath: x/y in Q2.30 with headroom, z in turn units.
   localparam int CORDIC_STEPS = 30;
   localparam int CW = 34;
   localparam int ZW = 33;
   localparam logic signed [CW-1:0] CORDIC_ONE = CW'(64'sd652032874);

   localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // Trig values are Q1.15 held in a few extra bits so that +1.0 is exact.
   localparam int FRAC_BITS = 15;
   localparam int TRIG_BITS = 18;
   localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

   // Intermediate coordinates: a rotated point grows by at most sqrt(3).
   localparam int MID_BITS = COORD_BITS + 3;
   localparam int PROD_BITS = MID_BITS + TRIG_BITS;
   localparam int SUM_BITS = PROD_BITS + 1;

   // Pipeline depths.
   localparam int SC_LAT = CORDIC_STEPS + 2;
   localparam int ROT_LAT = 2;
   localparam int PIPE_DEPTH = SC_LAT + 3 * ROT_LAT;

   // Output range, at intermediate width and at port width.
   localparam logic signed [MID_BITS-1:0] COORD_HI =
      MID_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [MID_BITS-1:0] COORD_LO = -COORD_HI - MID_BITS'(1);
   localparam logic signed [COORD_BITS-1:0] OUT_HI = COORD_HI[COORD_BITS-1:0];
   localparam logic signed [COORD_BITS-1:0] OUT_LO = COORD_LO[COORD_BITS-1:0];

   // Quadrant that the angle is folded into.
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      logic signed [MID_BITS-1:0] x;
      logic signed [MID_BITS-1:0] y;
      logic signed [MID_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic signed [TRIG_BITS-1:0] c;
      logic signed [TRIG_BITS-1:0] s;
   } trig_type;

   // True when a value lies outside the output coordinate range.
   function automatic logic coord_over(input logic signed [MID_BITS-1:0] v);
      return (v > COORD_HI) || (v < COORD_LO);
   endfunction

   // Clamp a value to the output coordinate range.
   function automatic logic signed [COORD_BITS-1:0] coord_sat(
      input logic signed [MID_BITS-1:0] v);
      logic signed [COORD_BITS-1:0] r;
      if (v > COORD_HI) begin
         r = OUT_HI;
      end else if (v < COORD_LO) begin
         r = OUT_LO;
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/erp_sincos.sv
// Pipelined CORDIC that turns one angle into its cosine and sine.
`default_nettype none

module erp_sincos (
   input  wire logic                                  clock,
   input  wire logic                                  enable,
   input  wire logic        [erp_pkg::ANGLE_BITS-1:0] angle,
   output logic signed      [erp_pkg::TRIG_BITS-1:0]  cos_out,
   output logic signed      [erp_pkg::TRIG_BITS-1:0]  sin_out
);
   import erp_pkg::*;

   logic [TURN_BITS-1:0] turn;
   logic [TURN_BITS-1:0] biased;
   logic [TURN_BITS-1:0] resid;
   quad_type             quad_in;
   logic signed [ZW-1:0] z_fold_in;

   logic signed [ZW-1:0] z_fold_ff;
   quad_type             quad_fold_ff;

   logic signed [CW-1:0] x_src [CORDIC_STEPS];
   logic signed [CW-1:0] y_src [CORDIC_STEPS];
   logic signed [ZW-1:0] z_src [CORDIC_STEPS];
   quad_type             q_src [CORDIC_STEPS];

   logic signed [CW-1:0] x_in [CORDIC_STEPS];
   logic signed [CW-1:0] y_in [CORDIC_STEPS];
   logic signed [ZW-1:0] z_in [CORDIC_STEPS];

   logic signed [CW-1:0] x_ff [CORDIC_STEPS];
   logic signed [CW-1:0] y_ff [CORDIC_STEPS];
   logic signed [ZW-1:0] z_ff [CORDIC_STEPS];
   quad_type             quad_ff [CORDIC_STEPS];

   logic signed [CW-1:0]        cos_sum;
   logic signed [CW-1:0]        sin_sum;
   logic signed [TRIG_BITS-1:0] cr;
   logic signed [TRIG_BITS-1:0] sr;
   logic signed [TRIG_BITS-1:0] cos_in;
   logic signed [TRIG_BITS-1:0] sin_in;
   logic signed [TRIG_BITS-1:0] cos_ff;
   logic signed [TRIG_BITS-1:0] sin_ff;

   // Fold the angle into the nearest quadrant; the residual is signed.
   always_comb begin
      turn      = {angle, {(TURN_BITS - ANGLE_BITS){1'b0}}};
      biased    = turn + HALF_QUAD;
      quad_in   = quad_type'(biased[TURN_BITS-1 -: 2]);
      resid     = turn - {biased[TURN_BITS-1 -: 2], {(TURN_BITS - 2){1'b0}}};
      z_fold_in = {{(ZW - TURN_BITS){resid[TURN_BITS-1]}}, resid};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z_fold_ff    <= z_fold_in;
         quad_fold_ff <= quad_in;
      end
   end

   // Each step reads the register of the step before it.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_src
      if (i == 0) begin : g_first
         assign x_src[i] = CORDIC_ONE;
         assign y_src[i] = '0;
         assign z_src[i] = z_fold_ff;
         assign q_src[i] = quad_fold_ff;
      end else begin : g_next
         assign x_src[i] = x_ff[i-1];
         assign y_src[i] = y_ff[i-1];
         assign z_src[i] = z_ff[i-1];
         assign q_src[i] = quad_ff[i-1];
      end
   end

   // One micro-rotation per stage, steered by the sign of the residual angle.
   always_comb begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z_src[i][ZW-1] == 1'b0) begin
            x_in[i] = x_src[i] - (y_src[i] >>> i);
            y_in[i] = y_src[i] + (x_src[i] >>> i);
            z_in[i] = z_src[i] - $signed(ZW'(ATAN_TABLE[i]));
         end else begin
            x_in[i] = x_src[i] + (y_src[i] >>> i);
            y_in[i] = y_src[i] - (x_src[i] >>> i);
            z_in[i] = z_src[i] + $signed(ZW'(ATAN_TABLE[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            quad_ff[i] <= q_src[i];
         end
      end
   end

   // Round to Q1.15 and undo the quadrant fold.
   always_comb begin
      cos_sum = x_ff[CORDIC_STEPS-1] + CW'(ROUND_BIAS);
      sin_sum = y_ff[CORDIC_STEPS-1] + CW'(ROUND_BIAS);
      cr      = cos_sum[FRAC_BITS +: TRIG_BITS];
      sr      = sin_sum[FRAC_BITS +: TRIG_BITS];
      case (quad_ff[CORDIC_STEPS-1])
         QUAD_0: begin
            cos_in = cr;
            sin_in = sr;
         end
         QUAD_1: begin
            cos_in = -sr;
            sin_in = cr;
         end
         QUAD_2: begin
            cos_in = -cr;
            sin_in = -sr;
         end
         default: begin
            cos_in = sr;
            sin_in = -cr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

>>> src/erp_rotate.sv
// Two-stage planar rotation: u = a*c + b*s, v = b*c - a*s, rounded to Q15.
`default_nettype none

module erp_rotate (
   input  wire logic                                 clock,
   input  wire logic                                 enable,
   input  wire logic signed [erp_pkg::MID_BITS-1:0]  a,
   input  wire logic signed [erp_pkg::MID_BITS-1:0]  b,
   input  wire erp_pkg::trig_type                    trig,
   output logic signed      [erp_pkg::MID_BITS-1:0]  u,
   output logic signed      [erp_pkg::MID_BITS-1:0]  v
);
   import erp_pkg::*;

   logic signed [PROD_BITS-1:0] prod_ac_ff;
   logic signed [PROD_BITS-1:0] prod_bs_ff;
   logic signed [PROD_BITS-1:0] prod_bc_ff;
   logic signed [PROD_BITS-1:0] prod_sa_ff;
   logic signed [SUM_BITS-1:0]  u_sum;
   logic signed [SUM_BITS-1:0]  v_sum;
   logic signed [MID_BITS-1:0]  u_ff;
   logic signed [MID_BITS-1:0]  v_ff;

   // Stage one: the four products.
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ac_ff <= PROD_BITS'(a) * PROD_BITS'(trig.c);
         prod_bs_ff <= PROD_BITS'(b) * PROD_BITS'(trig.s);
         prod_bc_ff <= PROD_BITS'(b) * PROD_BITS'(trig.c);
         prod_sa_ff <= PROD_BITS'(a) * PROD_BITS'(trig.s);
      end
   end

   // Stage two: combine and round half up.
   always_comb begin
      u_sum = SUM_BITS'(prod_ac_ff) + SUM_BITS'(prod_bs_ff) + SUM_BITS'(ROUND_BIAS);
      v_sum = SUM_BITS'(prod_bc_ff) - SUM_BITS'(prod_sa_ff) + SUM_BITS'(ROUND_BIAS);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         u_ff <= u_sum[FRAC_BITS +: MID_BITS];
         v_ff <= v_sum[FRAC_BITS +: MID_BITS];
      end
   end

   assign u = u_ff;
   assign v = v_ff;

endmodule

`default_nettype wire

>>> src/euler_rotate_point.sv
// Top level of the Euler point rotator: rotates a point about z, then y, then x.
//
// Usage: each request beat carries a Q7.12 point (req_px, req_py, req_pz) and
// three angles as unsigned fractions of a full turn. Each response beat
// carries the rotated point, clamped to the coordinate range, and
// rsp_clipped, which is set when any coordinate was clamped.
// A beat is taken on a rising edge where valid is high and stall is low.
// From request beat to response valid, a beat passes through the
// three parallel sine/cosine CORDIC pipelines (fold, 30 steps, rounding),
// the three planar rotations in turn (multiply, then add and round),
// and the saturating output register. Throughput is one beat per cycle
// unless the receiver stalls, with a new request taken every cycle while results drain.
// When the receiver stalls a waiting response, the whole pipeline holds
// and req_stall is raised; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and drops rsp_valid;
// req_stall is high while reset is asserted.
`default_nettype none

module euler_rotate_point (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [erp_pkg::COORD_BITS-1:0]  req_px,
   input  wire logic signed [erp_pkg::COORD_BITS-1:0]  req_py,
   input  wire logic signed [erp_pkg::COORD_BITS-1:0]  req_pz,
   input  wire logic        [erp_pkg::ANGLE_BITS-1:0]  req_angle_x,
   input  wire logic        [erp_pkg::ANGLE_BITS-1:0]  req_angle_y,
   input  wire logic        [erp_pkg::ANGLE_BITS-1:0]  req_angle_z,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed      [erp_pkg::COORD_BITS-1:0]  rsp_qx,
   output logic signed      [erp_pkg::COORD_BITS-1:0]  rsp_qy,
   output logic signed      [erp_pkg::COORD_BITS-1:0]  rsp_qz,
   output logic                                        rsp_clipped
);
   import erp_pkg::*;

   logic adv;

   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  rsp_valid_ff;

   trig_type trig_x;
   trig_type trig_y;
   trig_type trig_z;

   point_type pt_in;
   point_type pt_ff [SC_LAT];

   logic signed [MID_BITS-1:0] zd_ff  [ROT_LAT];
   trig_type                   tyd_ff [ROT_LAT];
   trig_type                   txd_ff [2*ROT_LAT];
   logic signed [MID_BITS-1:0] y1d_ff [ROT_LAT];
   logic signed [MID_BITS-1:0] x2d_ff [ROT_LAT];

   logic signed [MID_BITS-1:0] x1;
   logic signed [MID_BITS-1:0] y1;
   logic signed [MID_BITS-1:0] x2;
   logic signed [MID_BITS-1:0] z2;
   logic signed [MID_BITS-1:0] y3;
   logic signed [MID_BITS-1:0] z3;

   logic signed [COORD_BITS-1:0] qx_in;
   logic signed [COORD_BITS-1:0] qy_in;
   logic signed [COORD_BITS-1:0] qz_in;
   logic                         clip_in;
   logic signed [COORD_BITS-1:0] qx_ff;
   logic signed [COORD_BITS-1:0] qy_ff;
   logic signed [COORD_BITS-1:0] qz_ff;
   logic                         clip_ff;

   // The pipeline moves as one whenever the output register can take a beat.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || !adv;

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // Sine and cosine for all three angles in parallel.
   erp_sincos u_sincos_x (
      .clock   (clock),
      .enable  (adv),
      .angle   (req_angle_x),
      .cos_out (trig_x.c),
      .sin_out (trig_x.s)
   );

   erp_sincos u_sincos_y (
      .clock   (clock),
      .enable  (adv),
      .angle   (req_angle_y),
      .cos_out (trig_y.c),
      .sin_out (trig_y.s)
   );

   erp_sincos u_sincos_z (
      .clock   (clock),
      .enable  (adv),
      .angle   (req_angle_z),
      .cos_out (trig_z.c),
      .sin_out (trig_z.s)
   );

   // The point waits beside the CORDIC pipelines.
   assign pt_in.x = MID_BITS'(req_px);
   assign pt_in.y = MID_BITS'(req_py);
   assign pt_in.z = MID_BITS'(req_pz);

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff[0] <= pt_in;
         for (int i = 1; i < SC_LAT; i++) begin
            pt_ff[i] <= pt_ff[i-1];
         end
      end
   end

   // Rotation about z.
   erp_rotate u_rot_z (
      .clock  (clock),
      .enable (adv),
      .a      (pt_ff[SC_LAT-1].x),
      .b      (pt_ff[SC_LAT-1].y),
      .trig   (trig_z),
      .u      (x1),
      .v      (y1)
   );

   // Rotation about y.
   erp_rotate u_rot_y (
      .clock  (clock),
      .enable (adv),
      .a      (x1),
      .b      (zd_ff[ROT_LAT-1]),
      .trig   (tyd_ff[ROT_LAT-1]),
      .u      (x2),
      .v      (z2)
   );

   // Rotation about x.
   erp_rotate u_rot_x (
      .clock  (clock),
      .enable (adv),
      .a      (y1d_ff[ROT_LAT-1]),
      .b      (z2),
      .trig   (txd_ff[2*ROT_LAT-1]),
      .u      (y3),
      .v      (z3)
   );

   // Delay lines that keep the untouched operands in step with the rotations.
   always_ff @(posedge clock) begin
      if (adv) begin
         zd_ff[0]  <= pt_ff[SC_LAT-1].z;
         tyd_ff[0] <= trig_y;
         txd_ff[0] <= trig_x;
         y1d_ff[0] <= y1;
         x2d_ff[0] <= x2;
         for (int i = 1; i < ROT_LAT; i++) begin
            zd_ff[i]  <= zd_ff[i-1];
            tyd_ff[i] <= tyd_ff[i-1];
            y1d_ff[i] <= y1d_ff[i-1];
            x2d_ff[i] <= x2d_ff[i-1];
         end
         for (int i = 1; i < 2*ROT_LAT; i++) begin
            txd_ff[i] <= txd_ff[i-1];
         end
      end
   end

   // Saturate the final coordinates into the output register.
   always_comb begin
      qx_in   = coord_sat(x2d_ff[ROT_LAT-1]);
      qy_in   = coord_sat(y3);
      qz_in   = coord_sat(z3);
      clip_in = coord_over(x2d_ff[ROT_LAT-1]) || coord_over(y3) || coord_over(z3);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff   <= qx_in;
         qy_ff   <= qy_in;
         qz_ff   <= qz_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_qx      = qx_ff;
   assign rsp_qy      = qy_ff;
   assign rsp_qz      = qz_ff;
   assign rsp_clipped = clip_ff;

   // Reset leaves no response pending.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A clipped response must have at least one coordinate at a range limit.
   a_clip_at_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_qx == OUT_HI || rsp_qx == OUT_LO || rsp_qy == OUT_HI ||
          rsp_qy == OUT_LO || rsp_qz == OUT_HI || rsp_qz == OUT_LO))
      else $error("clipped set with no saturated coordinate");

   // While the input is stalled, the pipeline valid bits hold.
   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   // A taken response with nothing behind it leaves the output empty.
   a_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !vld_ff[PIPE_DEPTH-1]) |=> !rsp_valid)
      else $error("response repeated after it was taken");

endmodule

`default_nettype wire

>>> tb/euler_rotate_point_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for euler_rotate_point: directed and random points.

localparam int COORD_W = erp_pkg::COORD_BITS;
localparam int ANGLE_W = erp_pkg::ANGLE_BITS;

typedef logic signed [COORD_W-1:0] coord_word;
typedef logic [ANGLE_W-1:0] angle_word;

// Arctangent of 2^-i, in units of 2^-32 of a full turn.
localparam logic [31:0] ARCTAN_TURN [30] = '{
   32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
   32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
   32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
   32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
   32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
   32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
};

// Gain-compensated 1.0 in Q2.30, the CORDIC starting vector.
localparam longint CORDIC_START = 64'sd652032874;

localparam longint COORD_TOP = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
localparam longint COORD_BOTTOM = -COORD_TOP - 64'sd1;

typedef struct {
   coord_word qx;
   coord_word qy;
   coord_word qz;
   logic clipped;
} rotated_point;

// Predicts the rotated point for every accepted request and checks each response.
class rotated_point_board;
   rotated_point expected_points[$];
   int errors = 0;
   int noted = 0;
   int compared = 0;
   int clipped_count = 0;

   // Round half up on a Q15 product sum.
   function longint round_q15(input longint v);
      return (v + 64'sd16384) >>> 15;
   endfunction

   // Cosine and sine of a turn fraction, Q1.15, from a quadrant fold and a CORDIC.
   function void turn_sin_cos(input angle_word angle, output longint c, output longint s);
      logic [31:0] turn;
      logic [31:0] quad_bits;
      logic [31:0] resid;
      erp_pkg::quad_type quad;
      longint x, y, z, dx, dy, cr, sr;
      turn = 32'(angle) << (32 - ANGLE_W);
      quad_bits = (turn + 32'h2000_0000) >> 30;
      quad = erp_pkg::quad_type'(quad_bits[1:0]);
      resid = turn - (quad_bits << 30);
      z = longint'($signed(resid));
      x = CORDIC_START;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(ARCTAN_TURN[i]);
         end else begin
            x += dx;
            y -= dy;
            z += longint'(ARCTAN_TURN[i]);
         end
      end
      cr = round_q15(x);
      sr = round_q15(y);
      // Undo the quadrant fold.
      case (quad)
         erp_pkg::QUAD_0: begin
            c = cr;
            s = sr;
         end
         erp_pkg::QUAD_1: begin
            c = -sr;
            s = cr;
         end
         erp_pkg::QUAD_2: begin
            c = -cr;
            s = -sr;
         end
         default: begin
            c = sr;
            s = -cr;
         end
      endcase
   endfunction

   function coord_word clamp_coord(input longint v, inout logic clip);
      if (v > COORD_TOP) begin
         clip = 1'b1;
         return coord_word'(COORD_TOP);
      end
      if (v < COORD_BOTTOM) begin
         clip = 1'b1;
         return coord_word'(COORD_BOTTOM);
      end
      return coord_word'(v);
   endfunction

   // Rotate about z, then y, then x, and queue the saturated point.
   function void note_point(input coord_word px, py, pz, input angle_word ax, ay, az);
      longint cx, sx, cy, sy, cz, sz;
      longint x, y, z, x1, y1, x2, z2, y3, z3;
      rotated_point want;
      logic clip;
      turn_sin_cos(ax, cx, sx);
      turn_sin_cos(ay, cy, sy);
      turn_sin_cos(az, cz, sz);
      x = longint'(px);
      y = longint'(py);
      z = longint'(pz);
      x1 = round_q15(x * cz + y * sz);
      y1 = round_q15(y * cz - x * sz);
      x2 = round_q15(x1 * cy + z * sy);
      z2 = round_q15(z * cy - x1 * sy);
      y3 = round_q15(y1 * cx + z2 * sx);
      z3 = round_q15(z2 * cx - y1 * sx);
      clip = 1'b0;
      want.qx = clamp_coord(x2, clip);
      want.qy = clamp_coord(y3, clip);
      want.qz = clamp_coord(z3, clip);
      want.clipped = clip;
      if (clip) clipped_count++;
      noted++;
      expected_points.push_back(want);
   endfunction

   function void compare_field(input string name, input coord_word want, input coord_word got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   function void check_rotated(input coord_word qx, qy, qz, input logic clipped);
      rotated_point want;
      if (expected_points.size() == 0) begin
         errors++;
         $display("%0t: response beat with no point outstanding, expected none, got %0d %0d %0d",
                  $time, qx, qy, qz);
         return;
      end
      want = expected_points.pop_front();
      compared++;
      compare_field("qx", want.qx, qx);
      compare_field("qy", want.qy, qy);
      compare_field("qz", want.qz, qz);
      compare_field("clipped", coord_word'(want.clipped), coord_word'(clipped));
   endfunction

   function int pending();
      return expected_points.size();
   endfunction
endclass

module euler_rotate_point_test;

   localparam int RANDOM_POINTS = 630;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam coord_word COORD_MAX = coord_word'(COORD_TOP);
   localparam coord_word COORD_MIN = coord_word'(COORD_BOTTOM);
   localparam coord_word ONE_POINT = coord_word'(4096);

   localparam angle_word EIGHTH_TURN = angle_word'(1 << (ANGLE_W - 3));
   localparam angle_word QUARTER_TURN = angle_word'(1 << (ANGLE_W - 2));
   localparam angle_word HALF_TURN = angle_word'(1 << (ANGLE_W - 1));
   localparam angle_word THREE_QUARTER_TURN = QUARTER_TURN + HALF_TURN;
   localparam angle_word LAST_ANGLE = '1;

   typedef enum int {
      SHAPE_FULL,
      SHAPE_SMALL,
      SHAPE_CORNER
   } point_shape;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_word req_px = '0;
   coord_word req_py = '0;
   coord_word req_pz = '0;
   angle_word req_angle_x = '0;
   angle_word req_angle_y = '0;
   angle_word req_angle_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   coord_word rsp_qx;
   coord_word rsp_qy;
   coord_word rsp_qz;
   logic rsp_clipped;

   // Flags shared between the request side and the response side, and the directed count.
   logic steady = 1'b0;
   logic long_hold_due = 1'b0;
   int directed_count = 0;

   rotated_point_board board;

   euler_rotate_point DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_px      (req_px),
      .req_py      (req_py),
      .req_pz      (req_pz),
      .req_angle_x (req_angle_x),
      .req_angle_y (req_angle_y),
      .req_angle_z (req_angle_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_qx      (rsp_qx),
      .rsp_qy      (rsp_qy),
      .rsp_qz      (rsp_qz),
      .rsp_clipped (rsp_clipped)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic coord_word random_coord(input point_shape shape);
      case (shape)
         SHAPE_SMALL: return coord_word'($urandom_range(0, 16383)) - coord_word'(8192);
         SHAPE_CORNER: begin
            if ($urandom_range(0, 1) == 1) return COORD_MAX - coord_word'($urandom_range(0, 15));
            return COORD_MIN + coord_word'($urandom_range(0, 15));
         end
         default: return coord_word'($urandom());
      endcase
   endfunction

   // Near-edge angles sit within a few steps of an eighth-turn multiple,
   // which covers both quadrant centers and the fold boundaries.
   function automatic angle_word random_angle(input logic near_edge);
      if (near_edge) begin
         return angle_word'($urandom_range(0, 7)) * EIGHTH_TURN
                + angle_word'($urandom_range(0, 4)) - angle_word'(2);
      end
      return angle_word'($urandom());
   endfunction

   // Offer one request beat, wait for it to be taken, then idle a while.
   task automatic send_point(input coord_word px, py, pz, input angle_word ax, ay, az);
      int gap;
      req_valid <= 1'b1;
      req_px <= px;
      req_py <= py;
      req_pz <= pz;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_point(px, py, pz, ax, ay, az);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: check each taken beat and choose the stall for the next cycle.
   initial begin
      int hold_left;
      int run_left;
      logic stalling;
      hold_left = 0;
      run_left = 0;
      stalling = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            board.check_rotated(rsp_qx, rsp_qy, rsp_qz, rsp_clipped);
         end
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left = LONG_HOLD;
            stalling = 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
         end else if (steady) begin
            stalling = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            stalling = ($urandom_range(0, 2) == 0);
            run_left = pick_gap();
         end
         rsp_stall <= stalling;
      end
   end

   // Watchdog: ends the run when no beat moves for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: timeout, no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Request side: directed points, then random ones, then drain.
   initial begin
      point_shape shape;
      logic near_edge;
      int roll;
      board = new;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Identity, extremes, quarter, half and three-quarter turns, and the last angle.
      send_point(0, 0, 0, 0, 0, 0);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0);
      send_point(ONE_POINT, 0, 0, 0, 0, QUARTER_TURN);
      send_point(ONE_POINT, ONE_POINT, 0, 0, 0, HALF_TURN);
      send_point(ONE_POINT, 0, ONE_POINT, 0, THREE_QUARTER_TURN, 0);
      send_point(0, ONE_POINT, ONE_POINT, QUARTER_TURN, 0, 0);
      send_point(ONE_POINT, ONE_POINT, ONE_POINT, HALF_TURN, HALF_TURN, HALF_TURN);
      send_point(ONE_POINT, -ONE_POINT, ONE_POINT, LAST_ANGLE, LAST_ANGLE, LAST_ANGLE);
      // Angles on and beside the quadrant fold boundaries.
      send_point(ONE_POINT, ONE_POINT, ONE_POINT, EIGHTH_TURN, EIGHTH_TURN, EIGHTH_TURN);
      send_point(ONE_POINT, ONE_POINT, ONE_POINT, EIGHTH_TURN - angle_word'(1),
                 angle_word'(3) * EIGHTH_TURN - angle_word'(1),
                 angle_word'(5) * EIGHTH_TURN);
      // Corner growth past the range, which must saturate, and half turns of the range limits.
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, EIGHTH_TURN, EIGHTH_TURN, EIGHTH_TURN);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, EIGHTH_TURN,
                 angle_word'(3) * EIGHTH_TURN, angle_word'(7) * EIGHTH_TURN);
      send_point(COORD_MIN, 0, 0, 0, 0, HALF_TURN);
      send_point(COORD_MAX, 0, 0, 0, 0, HALF_TURN);
      send_point(0, COORD_MIN, 0, HALF_TURN, 0, 0);
      send_point(0, 0, COORD_MIN, 0, HALF_TURN, 0);
      // Tiny coordinates where rounding decides the result, and one extreme point.
      send_point(1, -1, 1, 1, 2, 3);
      send_point(-1, -1, -1, 21845, 43690, 12345);
      send_point(COORD_MAX, COORD_MIN, 0, QUARTER_TURN, THREE_QUARTER_TURN, QUARTER_TURN);
      directed_count = board.noted;

      for (int i = 0; i < RANDOM_POINTS; i++) begin
         if (i == 200) long_hold_due = 1'b1;
         steady = (i >= 400 && i < 480);
         roll = $urandom_range(0, 9);
         if (roll < 4) shape = SHAPE_FULL;
         else if (roll < 6) shape = SHAPE_SMALL;
         else shape = SHAPE_CORNER;
         near_edge = ($urandom_range(0, 4) == 0);
         send_point(random_coord(shape), random_coord(shape), random_coord(shape),
                    random_angle(near_edge), random_angle(near_edge), random_angle(near_edge));
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Rotated %0d points (%0d directed), checked %0d responses, %0d of them clipped.",
               board.noted, directed_count, board.compared, board.clipped_count);
      $display("Included fold boundaries, saturating corners and a %0d-cycle response hold.",
               LONG_HOLD);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
